>>> hdl/sps_pkg.sv
`default_nettype none
package sps_pkg;

    localparam int KIND_W = 3;
    localparam int INS_W  = 3;
    localparam int PAT_W  = 5;
    localparam int STEP_W = 4;

    localparam logic [KIND_W-1:0] KIND_READ       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TAP        = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ERASE      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNDO       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RESTORE    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_CLEAR_UNDO = 3'd6;

    // one request to the undo stacks
    typedef struct packed {
        logic              rd;
        logic              push;
        logic              pop;
        logic              clr;
        logic [INS_W-1:0]  ins;
        logic [STEP_W-1:0] step;
    } t_undo_req;

endpackage
`default_nettype wire

>>> hdl/sps_row_mem.sv
`default_nettype none
module sps_row_mem #(
    parameter int DEPTH = 192,
    parameter int WIDTH = 16,
    parameter int AW    = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> hdl/sps_undo.sv
`default_nettype none
module sps_undo
    import sps_pkg::*;
#(
    parameter int INSTRUMENTS = 6,
    parameter int UNDO_DEPTH  = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_undo_req         i_req,
    output logic      [STEP_W-1:0] o_entry,
    output logic                   o_ready
);

    localparam int IW    = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;
    localparam int TW    = (UNDO_DEPTH > 1) ? $clog2(UNDO_DEPTH) : 1;
    localparam int CW    = $clog2(UNDO_DEPTH + 1);
    localparam int DEPTH = INSTRUMENTS * UNDO_DEPTH;
    localparam int UAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [STEP_W-1:0] mem [DEPTH];
    logic [TW-1:0]     r_top [INSTRUMENTS];
    logic [CW-1:0]     r_cnt [INSTRUMENTS];

    logic [IW-1:0]  ins_ix;
    logic [TW-1:0]  top;
    logic [CW-1:0]  cnt;
    logic [TW-1:0]  top_inc;
    logic [TW-1:0]  top_dec;
    logic [UAW-1:0] base;

    // each stack is a ring: top points at the newest entry, count caps at the depth
    assign ins_ix  = IW'(i_req.ins);
    assign top     = r_top[ins_ix];
    assign cnt     = r_cnt[ins_ix];
    assign top_inc = (top == TW'(UNDO_DEPTH - 1)) ? '0 : TW'(top + TW'(1));
    assign top_dec = (top == '0) ? TW'(UNDO_DEPTH - 1) : TW'(top - TW'(1));
    assign base    = UAW'(UAW'(ins_ix) * UAW'(UNDO_DEPTH));
    assign o_ready = (cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            mem[UAW'(base + UAW'(top_inc))] <= i_req.step;
        end
        if (i_req.rd) begin
            o_entry <= mem[UAW'(base + UAW'(top))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < INSTRUMENTS; i++) begin
                r_top[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else if (i_req.push) begin
            r_top[ins_ix] <= top_inc;
            if (cnt != CW'(UNDO_DEPTH)) begin
                r_cnt[ins_ix] <= CW'(cnt + CW'(1));
            end
        end else if (i_req.pop) begin
            r_top[ins_ix] <= top_dec;
            r_cnt[ins_ix] <= CW'(cnt - CW'(1));
        end else if (i_req.clr) begin
            r_cnt[ins_ix] <= '0;
        end
    end

endmodule
`default_nettype wire

>>> hdl/step_pattern_store_with_undo.sv
`default_nettype none
// Flow: an accepted request goes from DISPATCH through FIN_RD and FIN_WAIT, then o_done rises;
// write, tap and erase in the pattern add MODIFY, undo with entries adds UNDO_ENT and MODIFY,
// a tap or erase that makes the first-edit backup adds COMMIT; an instrument out of range ends
// at DISPATCH; restore all walks every instrument, one row copy per marked instrument.
// Throughput: one request in flight, the next taken at the strobe's ending edge; no result stall.
// Reset: synchronous, active low; then a pass over every row clears the row memory (busy).
module step_pattern_store_with_undo
    import sps_pkg::*;
#(
    parameter int INSTRUMENTS = 6,
    parameter int STEPS       = 16,
    parameter int PATTERNS    = 32,
    parameter int UNDO_DEPTH  = 8,
    parameter int BACKUP_SLOT = 31
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [INS_W-1:0]  i_instrument,
    input  wire logic [PAT_W-1:0]  i_pattern,
    input  wire logic [STEP_W-1:0] i_step,
    input  wire logic              i_value,
    output logic                   o_done,
    output logic                   o_step_bit,
    output logic      [PAT_W-1:0]  o_backup_pattern,
    output logic                   o_undo_ready
);

    localparam int IW    = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;
    localparam int IXW   = $clog2(INSTRUMENTS + 1);
    localparam int PW    = $clog2(PATTERNS);
    localparam int SW    = $clog2(STEPS);
    localparam int DEPTH = INSTRUMENTS * PATTERNS;
    localparam int AW    = $clog2(DEPTH);
    localparam bit SLOT_OK = (BACKUP_SLOT < PATTERNS);
    localparam logic [PW-1:0] SLOT_IX = PW'(BACKUP_SLOT);

    typedef enum logic [9:0] {
        S_CLEAR    = 10'b0000000001,
        S_IDLE     = 10'b0000000010,
        S_DISPATCH = 10'b0000000100,
        S_UNDO_ENT = 10'b0000001000,
        S_MODIFY   = 10'b0000010000,
        S_COMMIT   = 10'b0000100000,
        S_RST_CHK  = 10'b0001000000,
        S_RST_WR   = 10'b0010000000,
        S_FIN_RD   = 10'b0100000000,
        S_FIN_WAIT = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [KIND_W-1:0] r_kind;
    logic [INS_W-1:0]  r_ins;
    logic [PAT_W-1:0]  r_pat;
    logic [STEP_W-1:0] r_st;
    logic              r_val;
    logic [STEPS-1:0]  r_new, n_new;
    logic [IXW-1:0]    r_idx, n_idx;
    logic [AW-1:0]     r_clr, n_clr;
    logic              r_done, n_done;
    logic              r_bit, n_bit;
    logic [PAT_W-1:0]  r_bkp, n_bkp;
    logic              r_urdy, n_urdy;
    logic [PAT_W-1:0]  r_mark [INSTRUMENTS];

    logic              ins_ok, pat_ok, st_ok, addr_ok;
    logic [IW-1:0]     ins_ix, idx_ix, mark_ix;
    logic [PAT_W-1:0]  cur_mark;
    logic [AW-1:0]     row_addr, slot_addr, idx_slot_addr, idx_mark_addr;
    logic [STEPS-1:0]  mask, ent_mask, row_q, mod_row;
    logic              backup;
    logic              mark_set, mark_clr;

    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [STEPS-1:0]  wr_data;

    t_undo_req         u_req;
    logic [STEP_W-1:0] u_entry;
    logic              u_ready;

    assign ins_ok  = (32'(r_ins) < INSTRUMENTS);
    assign pat_ok  = (32'(r_pat) < PATTERNS);
    assign st_ok   = (32'(r_st) < STEPS);
    assign addr_ok = pat_ok && st_ok;
    assign ins_ix  = IW'(r_ins);
    assign idx_ix  = r_idx[IW-1:0];

    // the mark array has one read port: the restore walk borrows it
    assign mark_ix  = (r_state == S_RST_CHK || r_state == S_RST_WR) ? idx_ix : ins_ix;
    assign cur_mark = r_mark[mark_ix];

    assign row_addr      = AW'(AW'(ins_ix) * AW'(PATTERNS) + AW'(PW'(r_pat)));
    assign slot_addr     = AW'(AW'(ins_ix) * AW'(PATTERNS) + AW'(SLOT_IX));
    assign idx_slot_addr = AW'(AW'(idx_ix) * AW'(PATTERNS) + AW'(SLOT_IX));
    assign idx_mark_addr = AW'(AW'(idx_ix) * AW'(PATTERNS) + AW'(PW'(cur_mark)));

    assign mask     = STEPS'(1) << SW'(r_st);
    assign ent_mask = STEPS'(1) << SW'(u_entry);
    assign backup   = (r_kind == KIND_TAP || r_kind == KIND_ERASE) && (cur_mark == '0);

    always_comb begin
        case (r_kind)
            KIND_WRITE: mod_row = r_val ? (row_q | mask) : (row_q & ~mask);
            KIND_TAP:   mod_row = row_q | mask;
            KIND_ERASE: mod_row = '0;
            KIND_UNDO:  mod_row = row_q & ~ent_mask;
            default:    mod_row = row_q;
        endcase
    end

    sps_row_mem #(
        .DEPTH (DEPTH),
        .WIDTH (STEPS),
        .AW    (AW)
    ) u_rows (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (row_q),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    sps_undo #(
        .INSTRUMENTS (INSTRUMENTS),
        .UNDO_DEPTH  (UNDO_DEPTH)
    ) u_undo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req),
        .o_entry (u_entry),
        .o_ready (u_ready)
    );

    always_comb begin
        n_state  = r_state;
        n_new    = r_new;
        n_idx    = r_idx;
        n_clr    = r_clr;
        n_done   = 1'b0;
        n_bit    = r_bit;
        n_bkp    = r_bkp;
        n_urdy   = r_urdy;
        rd_en    = 1'b0;
        rd_addr  = row_addr;
        wr_en    = 1'b0;
        wr_addr  = row_addr;
        wr_data  = mod_row;
        mark_set = 1'b0;
        mark_clr = 1'b0;
        u_req      = '0;
        u_req.ins  = r_ins;
        u_req.step = r_st;

        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
                n_clr   = AW'(r_clr + AW'(1));
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!ins_ok) begin
                    n_done  = 1'b1;
                    n_bit   = 1'b0;
                    n_bkp   = '0;
                    n_urdy  = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FIN_RD;
                    case (r_kind)
                        KIND_WRITE, KIND_TAP: begin
                            if (addr_ok) begin
                                rd_en   = 1'b1;
                                n_state = S_MODIFY;
                            end
                        end
                        KIND_ERASE: begin
                            if (pat_ok) begin
                                rd_en   = 1'b1;
                                n_state = S_MODIFY;
                            end
                        end
                        KIND_UNDO: begin
                            if (u_ready && pat_ok) begin
                                u_req.rd = 1'b1;
                                n_state  = S_UNDO_ENT;
                            end
                        end
                        KIND_RESTORE: begin
                            n_idx   = '0;
                            n_state = S_RST_CHK;
                        end
                        KIND_CLEAR_UNDO: begin
                            u_req.clr = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_UNDO_ENT: begin
                rd_en   = 1'b1;
                n_state = S_MODIFY;
            end
            S_MODIFY: begin
                u_req.push = (r_kind == KIND_TAP);
                u_req.pop  = (r_kind == KIND_UNDO);
                if (backup) begin
                    // save the untouched row first, then commit the edit
                    wr_en    = SLOT_OK;
                    wr_addr  = slot_addr;
                    wr_data  = row_q;
                    mark_set = 1'b1;
                    n_new    = mod_row;
                    n_state  = S_COMMIT;
                end else begin
                    wr_en   = 1'b1;
                    n_state = S_FIN_RD;
                end
            end
            S_COMMIT: begin
                wr_en   = 1'b1;
                wr_data = r_new;
                n_state = S_FIN_RD;
            end
            S_RST_CHK: begin
                rd_addr = idx_slot_addr;
                if (r_idx == IXW'(INSTRUMENTS)) begin
                    n_state = S_FIN_RD;
                end else if (cur_mark != '0) begin
                    rd_en   = SLOT_OK;
                    n_state = S_RST_WR;
                end else begin
                    n_idx = IXW'(r_idx + IXW'(1));
                end
            end
            S_RST_WR: begin
                wr_en    = 1'b1;
                wr_addr  = idx_mark_addr;
                wr_data  = SLOT_OK ? row_q : '0;
                mark_clr = 1'b1;
                n_idx    = IXW'(r_idx + IXW'(1));
                n_state  = S_RST_CHK;
            end
            S_FIN_RD: begin
                rd_en   = addr_ok;
                n_state = S_FIN_WAIT;
            end
            S_FIN_WAIT: begin
                n_done  = 1'b1;
                n_bit   = addr_ok ? row_q[SW'(r_st)] : 1'b0;
                n_bkp   = cur_mark;
                n_urdy  = u_ready;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_idx   <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < INSTRUMENTS; i++) begin
                r_mark[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_idx   <= n_idx;
            r_done  <= n_done;
            if (mark_set) begin
                r_mark[ins_ix] <= r_pat;
            end else if (mark_clr) begin
                r_mark[idx_ix] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_new  <= n_new;
        r_bit  <= n_bit;
        r_bkp  <= n_bkp;
        r_urdy <= n_urdy;
        if (r_state == S_IDLE && start) begin
            r_kind <= i_kind;
            r_ins  <= i_instrument;
            r_pat  <= i_pattern;
            r_st   <= i_step;
            r_val  <= i_value;
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_step_bit       = r_bit;
    assign o_backup_pattern = r_bkp;
    assign o_undo_ready     = r_urdy;

endmodule
`default_nettype wire

>>> hdl/sps_checker.sv
`default_nettype none
module sps_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_done
);

    // a taken request keeps the block busy until its result
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but busy not raised");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // a result only ends a busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("result strobe outside a finished request");

    // reset starts the clearing pass
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_done))
        else $error("block not busy clearing after reset");

endmodule

bind step_pattern_store_with_undo sps_checker u_sps_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);
`default_nettype wire

>>> tb/sv/step_store_checker.sv
`default_nettype none
module step_store_checker
    import sps_pkg::*;
#(
    parameter int INSTRUMENTS = 6,
    parameter int STEPS       = 16,
    parameter int PATTERNS    = 32,
    parameter int UNDO_DEPTH  = 8,
    parameter int BACKUP_SLOT = 31
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [INS_W-1:0]  i_instrument,
    input  wire logic [PAT_W-1:0]  i_pattern,
    input  wire logic [STEP_W-1:0] i_step,
    input  wire logic              i_value,
    input  wire logic              i_done,
    input  wire logic              i_step_bit,
    input  wire logic [PAT_W-1:0]  i_backup_pattern,
    input  wire logic              i_undo_ready,
    output int                     o_mismatches,
    output int                     o_pending
);

    typedef struct packed {
        logic             step_bit;
        logic [PAT_W-1:0] backup_pattern;
        logic             undo_ready;
    } t_step_result;

    logic [STEPS-1:0]  rows       [INSTRUMENTS][PATTERNS];
    logic [PAT_W-1:0]  marks      [INSTRUMENTS];
    logic [STEP_W-1:0] undo_step  [INSTRUMENTS][UNDO_DEPTH];
    logic              undo_live  [INSTRUMENTS][UNDO_DEPTH];
    t_step_result      expected_results[$];
    int                mismatch_count = 0;

    function automatic logic [STEPS-1:0] row_get(int ins, int pat);
        if (pat >= PATTERNS)
            return '0;
        return rows[ins][pat];
    endfunction

    function automatic void row_put(int ins, int pat, logic [STEPS-1:0] row);
        if (pat < PATTERNS)
            rows[ins][pat] = row;
    endfunction

    // first edit of an instrument copies the pattern into the backup slot
    function automatic void backup_on_first_edit(int ins, int pat);
        if (marks[ins] == '0) begin
            row_put(ins, BACKUP_SLOT, row_get(ins, pat));
            marks[ins] = pat[PAT_W-1:0];
        end
    endfunction

    function automatic t_step_result apply_request(
        logic [KIND_W-1:0] kind,
        logic [INS_W-1:0]  ins_f,
        logic [PAT_W-1:0]  pat_f,
        logic [STEP_W-1:0] st_f,
        logic              val
    );
        t_step_result     res;
        int               ins;
        int               pat;
        int               st;
        logic             addr_ok;
        logic [STEPS-1:0] row;
        res     = '0;
        ins     = int'(ins_f);
        pat     = int'(pat_f);
        st      = int'(st_f);
        addr_ok = (pat < PATTERNS) && (st < STEPS);
        if (ins >= INSTRUMENTS)
            return res;

        case (kind)
            KIND_WRITE: if (addr_ok) begin
                row     = row_get(ins, pat);
                row[st] = val;
                row_put(ins, pat, row);
            end
            KIND_TAP: if (addr_ok) begin
                backup_on_first_edit(ins, pat);
                row     = row_get(ins, pat);
                row[st] = 1'b1;
                row_put(ins, pat, row);
                // push; the oldest entry falls off the bottom
                for (int i = UNDO_DEPTH - 1; i > 0; i--) begin
                    undo_step[ins][i] = undo_step[ins][i-1];
                    undo_live[ins][i] = undo_live[ins][i-1];
                end
                undo_step[ins][0] = st_f;
                undo_live[ins][0] = 1'b1;
            end
            KIND_ERASE: if (pat < PATTERNS) begin
                backup_on_first_edit(ins, pat);
                row_put(ins, pat, '0);
            end
            KIND_UNDO: if (undo_live[ins][0] && pat < PATTERNS) begin
                row = row_get(ins, pat);
                row[undo_step[ins][0]] = 1'b0;
                row_put(ins, pat, row);
                for (int i = 0; i + 1 < UNDO_DEPTH; i++) begin
                    undo_step[ins][i] = undo_step[ins][i+1];
                    undo_live[ins][i] = undo_live[ins][i+1];
                end
                undo_step[ins][UNDO_DEPTH-1] = '0;
                undo_live[ins][UNDO_DEPTH-1] = 1'b0;
            end
            KIND_RESTORE: begin
                for (int i = 0; i < INSTRUMENTS; i++) begin
                    if (marks[i] != '0) begin
                        row_put(i, int'(marks[i]), row_get(i, BACKUP_SLOT));
                        marks[i] = '0;
                    end
                end
            end
            KIND_CLEAR_UNDO: begin
                for (int i = 0; i < UNDO_DEPTH; i++) begin
                    undo_step[ins][i] = '0;
                    undo_live[ins][i] = 1'b0;
                end
            end
            default: ;
        endcase

        if (addr_ok) begin
            row          = row_get(ins, pat);
            res.step_bit = row[st];
        end
        res.backup_pattern = marks[ins];
        res.undo_ready     = undo_live[ins][0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_step_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < INSTRUMENTS; i++) begin
                marks[i] = '0;
                for (int p = 0; p < PATTERNS; p++)
                    rows[i][p] = '0;
                for (int d = 0; d < UNDO_DEPTH; d++) begin
                    undo_step[i][d] = '0;
                    undo_live[i][d] = 1'b0;
                end
            end
            expected_results.delete();
        end else begin
            // retire before accepting: a new request may be taken on the strobe edge
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unrequested result: step_bit=%0d backup=%0d undo_ready=%0d",
                                 i_step_bit, i_backup_pattern, i_undo_ready);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_step_bit !== want.step_bit ||
                        i_backup_pattern !== want.backup_pattern ||
                        i_undo_ready !== want.undo_ready) begin
                        if (mismatch_count < 10)
                            $display({"mismatch: expected step_bit=%0d backup=%0d ",
                                      "undo_ready=%0d, got step_bit=%0d backup=%0d ",
                                      "undo_ready=%0d"},
                                     want.step_bit, want.backup_pattern, want.undo_ready,
                                     i_step_bit, i_backup_pattern, i_undo_ready);
                        mismatch_count++;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(apply_request(i_kind, i_instrument, i_pattern,
                                                         i_step, i_value));
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_results.size();
    end

endmodule
`default_nettype wire

>>> tb/sv/step_pattern_store_with_undo_tb.sv
`default_nettype none
module step_pattern_store_with_undo_tb;
    import sps_pkg::*;

    localparam int NUM_INSTRUMENTS = 6;
    localparam int NUM_STEPS       = 16;
    localparam int NUM_PATTERNS    = 32;
    localparam int STACK_DEPTH     = 8;
    localparam int SLOT            = 31;
    localparam int RANDOM_ITEMS    = 750;
    localparam int DRAIN_CYCLES    = 40;

    // kind code the block leaves unassigned; treated as a read
    localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [KIND_W-1:0] i_kind;
    logic [INS_W-1:0]  i_instrument;
    logic [PAT_W-1:0]  i_pattern;
    logic [STEP_W-1:0] i_step;
    logic              i_value;
    logic              o_done;
    logic              o_step_bit;
    logic [PAT_W-1:0]  o_backup_pattern;
    logic              o_undo_ready;
    int                mismatches;
    int                pending;
    int                burst_left = 0;
    int                valid_sent = 0;

    always #5 i_clk = ~i_clk;

    step_pattern_store_with_undo #(
        .INSTRUMENTS (NUM_INSTRUMENTS),
        .STEPS       (NUM_STEPS),
        .PATTERNS    (NUM_PATTERNS),
        .UNDO_DEPTH  (STACK_DEPTH),
        .BACKUP_SLOT (SLOT)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_instrument     (i_instrument),
        .i_pattern        (i_pattern),
        .i_step           (i_step),
        .i_value          (i_value),
        .o_done           (o_done),
        .o_step_bit       (o_step_bit),
        .o_backup_pattern (o_backup_pattern),
        .o_undo_ready     (o_undo_ready)
    );

    step_store_checker #(
        .INSTRUMENTS (NUM_INSTRUMENTS),
        .STEPS       (NUM_STEPS),
        .PATTERNS    (NUM_PATTERNS),
        .UNDO_DEPTH  (STACK_DEPTH),
        .BACKUP_SLOT (SLOT)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_kind           (i_kind),
        .i_instrument     (i_instrument),
        .i_pattern        (i_pattern),
        .i_step           (i_step),
        .i_value          (i_value),
        .i_done           (o_done),
        .i_step_bit       (o_step_bit),
        .i_backup_pattern (o_backup_pattern),
        .i_undo_ready     (o_undo_ready),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    // hold the request until taken; then keep bursting or drop start for a gap
    task automatic send_request(
        input logic [KIND_W-1:0] kind,
        input logic [INS_W-1:0]  ins,
        input logic [PAT_W-1:0]  pat,
        input logic [STEP_W-1:0] st,
        input logic              val
    );
        start        <= 1'b1;
        i_kind       <= kind;
        i_instrument <= ins;
        i_pattern    <= pat;
        i_step       <= st;
        i_value      <= val;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (ins < NUM_INSTRUMENTS)
            valid_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 60 : int'($urandom_range(0, 8));
        end
    endtask

    task automatic hold_off();
        start      <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [KIND_W-1:0] kind;
        logic [INS_W-1:0]  ins;
        logic [PAT_W-1:0]  pat;
        int                r;
        int                len;

        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_kind       <= KIND_READ;
        i_instrument <= '0;
        i_pattern    <= '0;
        i_step       <= '0;
        i_value      <= 1'b0;
        repeat (6)
            @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every kind, first-edit backup, overflow, empty undo
        send_request(KIND_READ,  3'd0, 5'd0,  4'd0,  1'b0);
        send_request(KIND_WRITE, 3'd5, 5'd31, 4'd15, 1'b1);
        send_request(KIND_WRITE, 3'd5, 5'd31, 4'd15, 1'b0);
        send_request(KIND_UNDO,  3'd1, 5'd3,  4'd2,  1'b0);
        send_request(KIND_TAP,   3'd0, 5'd0,  4'd3,  1'b0);
        send_request(KIND_TAP,   3'd0, 5'd7,  4'd4,  1'b1);
        send_request(KIND_ERASE, 3'd2, 5'd31, 4'd0,  1'b0);
        send_request(KIND_RESTORE, 3'd2, 5'd31, 4'd0, 1'b0);
        for (int s = 0; s < 10; s++)
            send_request(KIND_TAP, 3'd3, 5'd9, s[STEP_W-1:0], 1'b0);
        send_request(KIND_UNDO,       3'd3, 5'd9,  4'd0,  1'b0);
        send_request(KIND_CLEAR_UNDO, 3'd3, 5'd9,  4'd0,  1'b0);
        send_request(KIND_UNDO,       3'd3, 5'd9,  4'd0,  1'b0);
        send_request(KIND_SPARE,      3'd0, 5'd7,  4'd4,  1'b0);
        send_request(KIND_TAP,        3'd6, 5'd1,  4'd1,  1'b1);
        send_request(KIND_READ,       3'd7, 5'd31, 4'd15, 1'b1);
        send_request(KIND_WRITE,      3'd4, 5'd1,  4'd1,  1'b1);
        hold_off();

        valid_sent = 0;
        while (valid_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 49) == 0)
                hold_off();
            ins = ($urandom_range(0, 15) == 0) ? INS_W'($urandom_range(6, 7)) :
                                                 INS_W'($urandom_range(0, 5));
            r   = $urandom_range(0, 99);
            pat = (r < 15) ? 5'd0 : (r < 25) ? 5'd31 :
                  (r < 60) ? PAT_W'($urandom_range(1, 4)) : PAT_W'($urandom_range(0, 31));
            if ($urandom_range(0, 9) < 7) begin
                // edit run on one pattern: mostly taps and undos, maybe a restore
                len = $urandom_range(2, 14);
                for (int n = 0; n < len; n++) begin
                    r    = $urandom_range(0, 99);
                    kind = (r < 45) ? KIND_TAP  : (r < 70) ? KIND_UNDO  :
                           (r < 80) ? KIND_READ : (r < 88) ? KIND_WRITE :
                           (r < 94) ? KIND_ERASE : KIND_CLEAR_UNDO;
                    send_request(kind, ins, pat, STEP_W'($urandom_range(0, 15)),
                                 1'($urandom_range(0, 1)));
                end
                if ($urandom_range(0, 1) == 1)
                    send_request(KIND_RESTORE, ins, pat, STEP_W'($urandom_range(0, 15)),
                                 1'($urandom_range(0, 1)));
            end else begin
                send_request(KIND_W'($urandom_range(0, 7)), ins, pat,
                             STEP_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            end
        end

        hold_off();
        repeat (DRAIN_CYCLES)
            @(posedge i_clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
